// ===== rtl/core/lrm_pkg.sv =====
// Shared types and constants for the linear resample mixer.
// Depends on nothing; every module of the block imports it.
`default_nettype none

package lrm_pkg;

    localparam int RATE_W = 18;
    localparam int GAIN_W = 11;
    localparam int IDX_W  = 32;
    localparam int SAMP_W = 16;
    localparam int CFG_W  = 32;
    localparam int CFG_IDX_W = 3;

    // Source sample rate of the track, and the floor applied to the output rate.
    localparam int INPUT_RATE = 44100;
    localparam int MIN_RATE   = INPUT_RATE / 4;

    localparam logic signed [SAMP_W-1:0] SAMP_MAX = 16'sh7FFF;
    localparam logic signed [SAMP_W-1:0] SAMP_MIN = 16'sh8000;

    localparam logic [CFG_IDX_W-1:0] CFG_OUTPUT_RATE  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN         = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TRACK_FRAMES = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_LOOP_START   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_LOOP_ENABLE  = 3'd4;

    typedef enum logic [1:0] {
        KIND_START = 2'd0,
        KIND_FRAME = 2'd1,
        KIND_TICK  = 2'd2,
        KIND_STOP  = 2'd3
    } t_kind;

    typedef enum logic [3:0] {
        S_IDLE,
        S_EXEC,
        S_PHCLAMP,
        S_WEIGHT,
        S_MUL0,
        S_MUL1,
        S_ACC,
        S_ABS,
        S_DIV,
        S_GAIN,
        S_SCALE,
        S_MIX,
        S_PHSTEP0,
        S_PHSTEP,
        S_PREP,
        S_DONE
    } t_state;

    typedef struct packed {
        logic              ge;
        logic [RATE_W:0]   diff;
    } t_csub_res;

endpackage

`default_nettype wire

// ===== rtl/core/lrm_csub.sv =====
// Shared compare-subtract unit: one step of the divider, phase wrap and clamps.
// Depends on lrm_pkg.
`default_nettype none

module lrm_csub (
    input  wire logic [lrm_pkg::RATE_W:0]   i_x,
    input  wire logic [lrm_pkg::RATE_W-1:0] i_d,
    output lrm_pkg::t_csub_res              o_res
);
    import lrm_pkg::*;

    logic [RATE_W:0] w_d;

    assign w_d        = {1'b0, i_d};
    assign o_res.ge   = (i_x >= w_d);
    assign o_res.diff = i_x - w_d;

endmodule

`default_nettype wire

// ===== rtl/core/lrm_mul.sv =====
// Shared registered multiplier: signed sample times unsigned weight or gain.
// Depends on lrm_pkg.
`default_nettype none

module lrm_mul (
    input  wire logic                            i_clk,
    input  wire logic signed [lrm_pkg::SAMP_W:0] i_a,
    input  wire logic [lrm_pkg::RATE_W-1:0]      i_b,
    output logic signed [35:0]                   o_p
);
    import lrm_pkg::*;

    logic signed [35:0] r_p;

    always_ff @(posedge i_clk) begin
        r_p <= i_a * $signed({1'b0, i_b});
    end

    assign o_p = r_p;

endmodule

`default_nettype wire

// ===== rtl/core/linear_resample_mixer.sv =====
// Top level of the linear resample mixer: sequencer, track state and output register.
// Depends on lrm_pkg, lrm_mul and lrm_csub.
//
//  channel   direction  handshake                 payload
//  input     in         i_valid / o_stall         i_kind, i_left, i_right
//  result    out        o_valid / i_stall         o_out_left .. o_misuse
//  config    in         i_cfg_we                  i_cfg_idx, i_cfg_data
//
// Start and accepted frame beats go through the execute, prepare and done states;
// stop, refused frames and pass-through ticks go from execute straight to done.
// In a mixing tick each channel runs a 16-step restoring divide on the shared compare-subtract
// unit, and the phase then wraps one rate period per cycle.
// Reset is synchronous and active low; it stops playback and restores register defaults.
// A new beat is accepted while a finished result still waits in the output register;
// the next result is held back only until that register is taken.
`default_nettype none

module linear_resample_mixer (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_valid,
    output logic                                     o_stall,
    input  wire logic [1:0]                          i_kind,
    input  wire logic signed [lrm_pkg::SAMP_W-1:0]   i_left,
    input  wire logic signed [lrm_pkg::SAMP_W-1:0]   i_right,
    output logic                                     o_valid,
    input  wire logic                                i_stall,
    output logic signed [lrm_pkg::SAMP_W-1:0]        o_out_left,
    output logic signed [lrm_pkg::SAMP_W-1:0]        o_out_right,
    output logic                                     o_fetch_valid,
    output logic [lrm_pkg::IDX_W-1:0]                o_fetch_index,
    output logic                                     o_active,
    output logic                                     o_misuse,
    input  wire logic                                i_cfg_we,
    input  wire logic [lrm_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  wire logic [lrm_pkg::CFG_W-1:0]           i_cfg_data
);
    import lrm_pkg::*;

    // Configuration registers.
    logic [RATE_W-1:0] r_output_rate;
    logic [GAIN_W-1:0] r_gain;
    logic [IDX_W-1:0]  r_track_frames;
    logic [IDX_W-1:0]  r_loop_start;
    logic              r_loop_en;

    // Playback state.
    logic signed [SAMP_W-1:0] r_cur_l, r_cur_r, r_nxt_l, r_nxt_r;
    logic [RATE_W-1:0]        r_phase;
    logic [IDX_W-1:0]         r_frame_idx;
    logic                     r_running;
    logic [2:0]               r_owed;

    // Work registers of the sequencer.
    t_state                   r_state, n_state;
    t_kind                    r_kind;
    logic signed [SAMP_W-1:0] r_mix_l, r_mix_r;
    logic signed [SAMP_W-1:0] r_res_l, r_res_r;
    logic                     r_misuse;
    logic [RATE_W-1:0]        r_rate;
    logic [RATE_W-1:0]        r_ph;
    logic [RATE_W-1:0]        r_w0;
    logic signed [35:0]       r_acc;
    logic [RATE_W:0]          r_rem;
    logic [SAMP_W-1:0]        r_lo;
    logic                     r_neg;
    logic [3:0]               r_cnt;
    logic                     r_chan;

    // Output register.
    logic                     r_out_valid;
    logic signed [SAMP_W-1:0] r_out_l, r_out_r;
    logic                     r_out_fv;
    logic [IDX_W-1:0]         r_out_idx;
    logic                     r_out_active;
    logic                     r_out_misuse;

    // Shared units.
    logic [RATE_W:0]          w_cs_x;
    logic [RATE_W-1:0]        w_cs_d;
    t_csub_res                w_cs;
    logic signed [SAMP_W:0]   w_mul_a;
    logic [RATE_W-1:0]        w_mul_b;
    logic signed [35:0]       w_mul_p;

    logic                     w_accept;
    logic                     w_load;
    logic [35:0]              w_mag;
    logic [SAMP_W:0]          w_q;
    logic signed [SAMP_W:0]   w_interp;
    logic signed [35:0]       w_p_adj;
    logic signed [SAMP_W-1:0] w_mix;
    logic signed [19:0]       w_sum;
    logic signed [SAMP_W-1:0] w_sat;
    logic                     w_fv;

    lrm_csub u_csub (
        .i_x   (w_cs_x),
        .i_d   (w_cs_d),
        .o_res (w_cs)
    );

    lrm_mul u_mul (
        .i_clk (i_clk),
        .i_a   (w_mul_a),
        .i_b   (w_mul_b),
        .o_p   (w_mul_p)
    );

    assign o_stall  = !i_rst_n || (r_state != S_IDLE);
    assign w_accept = i_valid && !o_stall;
    assign w_load   = (r_state == S_DONE) && (!r_out_valid || !i_stall);

    // Operand selection for the shared units.
    always_comb begin
        w_cs_x  = '0;
        w_cs_d  = r_rate;
        w_mul_a = '0;
        w_mul_b = '0;
        case (r_state)
            S_PHCLAMP: w_cs_x = {1'b0, r_phase};
            S_WEIGHT: begin
                w_cs_x = {1'b0, r_rate};
                w_cs_d = r_ph;
            end
            S_DIV:    w_cs_x = {r_rem[RATE_W-1:0], r_lo[SAMP_W-1]};
            S_PHSTEP: w_cs_x = r_rem;
            S_MUL0: begin
                w_mul_a = r_chan ? {r_cur_r[SAMP_W-1], r_cur_r} : {r_cur_l[SAMP_W-1], r_cur_l};
                w_mul_b = r_w0;
            end
            S_MUL1: begin
                w_mul_a = r_chan ? {r_nxt_r[SAMP_W-1], r_nxt_r} : {r_nxt_l[SAMP_W-1], r_nxt_l};
                w_mul_b = r_ph;
            end
            S_GAIN: begin
                w_mul_a = w_interp;
                w_mul_b = {{(RATE_W-GAIN_W){1'b0}}, r_gain};
            end
            default: ;
        endcase
    end

    assign w_mag    = r_acc[35] ? 36'(-r_acc) : r_acc;
    assign w_q      = {1'b0, r_lo};
    assign w_interp = r_neg ? (17'sd0 - $signed(w_q)) : $signed(w_q);
    // Division by 256 truncates toward zero, so negative products are biased first.
    assign w_p_adj  = w_mul_p + (w_mul_p[35] ? 36'sd255 : 36'sd0);
    assign w_mix    = r_chan ? r_mix_r : r_mix_l;
    assign w_sum    = $signed({{4{w_mix[SAMP_W-1]}}, w_mix}) + $signed(r_acc[19:0]);

    always_comb begin
        if (w_sum > 20'sd32767) begin
            w_sat = SAMP_MAX;
        end else if (w_sum < -20'sd32768) begin
            w_sat = SAMP_MIN;
        end else begin
            w_sat = w_sum[SAMP_W-1:0];
        end
    end

    assign w_fv = r_running && (r_owed != 3'd0);

    // Next-state logic of the sequencer.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                case (r_kind)
                    KIND_START: n_state = S_PREP;
                    KIND_FRAME: n_state = (r_running && r_owed != 3'd0) ? S_PREP : S_DONE;
                    KIND_TICK:  n_state = (r_running && r_owed == 3'd0) ? S_PHCLAMP : S_DONE;
                    default:    n_state = S_DONE;
                endcase
            end
            S_PHCLAMP: n_state = S_WEIGHT;
            S_WEIGHT:  n_state = S_MUL0;
            S_MUL0:    n_state = S_MUL1;
            S_MUL1:    n_state = S_ACC;
            S_ACC:     n_state = S_ABS;
            S_ABS:     n_state = S_DIV;
            S_DIV: begin
                if (r_cnt == 4'd15) begin
                    n_state = S_GAIN;
                end
            end
            S_GAIN:    n_state = S_SCALE;
            S_SCALE:   n_state = S_MIX;
            S_MIX:     n_state = r_chan ? S_PHSTEP0 : S_MUL0;
            S_PHSTEP0: n_state = S_PHSTEP;
            S_PHSTEP: begin
                if (!w_cs.ge) begin
                    n_state = S_PREP;
                end
            end
            S_PREP:    n_state = S_DONE;
            S_DONE: begin
                if (w_load) begin
                    n_state = S_IDLE;
                end
            end
            default:   n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_output_rate  <= 18'd48000;
            r_gain         <= 11'd256;
            r_track_frames <= '0;
            r_loop_start   <= '0;
            r_loop_en      <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_OUTPUT_RATE:  r_output_rate  <= i_cfg_data[RATE_W-1:0];
                CFG_GAIN:         r_gain         <= i_cfg_data[GAIN_W-1:0];
                CFG_TRACK_FRAMES: r_track_frames <= i_cfg_data[IDX_W-1:0];
                CFG_LOOP_START:   r_loop_start   <= i_cfg_data[IDX_W-1:0];
                CFG_LOOP_ENABLE:  r_loop_en      <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // Playback state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur_l     <= '0;
            r_cur_r     <= '0;
            r_nxt_l     <= '0;
            r_nxt_r     <= '0;
            r_phase     <= '0;
            r_frame_idx <= '0;
            r_running   <= 1'b0;
            r_owed      <= '0;
        end else begin
            case (r_state)
                S_EXEC: begin
                    case (r_kind)
                        KIND_START, KIND_STOP: begin
                            r_cur_l     <= '0;
                            r_cur_r     <= '0;
                            r_nxt_l     <= '0;
                            r_nxt_r     <= '0;
                            r_phase     <= '0;
                            r_frame_idx <= '0;
                            r_running   <= (r_kind == KIND_START);
                            r_owed      <= (r_kind == KIND_START) ? 3'd2 : 3'd0;
                        end
                        KIND_FRAME: begin
                            if (r_running && r_owed != 3'd0) begin
                                r_cur_l     <= r_nxt_l;
                                r_cur_r     <= r_nxt_r;
                                r_nxt_l     <= r_mix_l;
                                r_nxt_r     <= r_mix_r;
                                r_frame_idx <= r_frame_idx + 32'd1;
                                r_owed      <= r_owed - 3'd1;
                            end
                        end
                        default: ;
                    endcase
                end
                S_PHSTEP0: r_owed <= '0;
                S_PHSTEP: begin
                    if (w_cs.ge) begin
                        r_owed <= r_owed + 3'd1;
                    end else begin
                        r_phase <= r_rem[RATE_W-1:0];
                    end
                end
                S_PREP: begin
                    // Wrap to the loop point or end playback at the track end.
                    if (w_fv && r_frame_idx >= r_track_frames) begin
                        if (r_loop_en && r_loop_start < r_track_frames) begin
                            r_frame_idx <= r_loop_start;
                        end else begin
                            r_running <= 1'b0;
                            r_owed    <= '0;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    // Datapath work registers.
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    r_kind   <= t_kind'(i_kind);
                    r_mix_l  <= i_left;
                    r_mix_r  <= i_right;
                    r_res_l  <= '0;
                    r_res_r  <= '0;
                    r_misuse <= 1'b0;
                end
            end
            S_EXEC: begin
                r_chan <= 1'b0;
                r_rate <= (r_output_rate < RATE_W'(MIN_RATE)) ? RATE_W'(MIN_RATE)
                                                              : r_output_rate;
                case (r_kind)
                    KIND_FRAME: begin
                        if (!r_running || r_owed == 3'd0) begin
                            r_misuse <= 1'b1;
                        end
                    end
                    KIND_TICK: begin
                        if (!r_running || r_owed != 3'd0) begin
                            r_res_l  <= r_mix_l;
                            r_res_r  <= r_mix_r;
                            r_misuse <= r_running;
                        end
                    end
                    default: ;
                endcase
            end
            // A phase left at or above a lowered rate is pulled back to rate - 1.
            S_PHCLAMP: r_ph <= w_cs.ge ? (r_rate - 18'd1) : r_phase;
            S_WEIGHT:  r_w0 <= w_cs.diff[RATE_W-1:0];
            S_MUL1:    r_acc <= w_mul_p;
            S_ACC:     r_acc <= r_acc + w_mul_p;
            S_ABS: begin
                // The quotient fits in 16 bits, so the upper dividend bits start below the rate.
                r_neg <= r_acc[35];
                r_rem <= w_mag[34:16];
                r_lo  <= w_mag[15:0];
                r_cnt <= '0;
            end
            S_DIV: begin
                r_rem <= w_cs.ge ? w_cs.diff : w_cs_x;
                r_lo  <= {r_lo[SAMP_W-2:0], w_cs.ge};
                r_cnt <= r_cnt + 4'd1;
            end
            S_SCALE:   r_acc <= w_p_adj >>> 8;
            S_MIX: begin
                if (r_chan) begin
                    r_res_r <= w_sat;
                end else begin
                    r_res_l <= w_sat;
                end
                r_chan <= 1'b1;
            end
            S_PHSTEP0: r_rem <= {1'b0, r_ph} + (RATE_W+1)'(INPUT_RATE);
            S_PHSTEP: begin
                if (w_cs.ge) begin
                    r_rem <= w_cs.diff;
                end
            end
            default: ;
        endcase
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_out_l      <= r_res_l;
            r_out_r      <= r_res_r;
            r_out_fv     <= w_fv;
            r_out_idx    <= w_fv ? r_frame_idx : '0;
            r_out_active <= r_running;
            r_out_misuse <= r_misuse;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_out_left    = r_out_l;
    assign o_out_right   = r_out_r;
    assign o_fetch_valid = r_out_fv;
    assign o_fetch_index = r_out_idx;
    assign o_active      = r_out_active;
    assign o_misuse      = r_out_misuse;

    // Frames can only be owed while the track is playing.
    a_owed_running: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_owed != 3'd0) |-> r_running)
        else $error("frames owed while stopped");

    // The divider remainder never reaches the divisor.
    a_rem_below_rate: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> (r_rem < {1'b0, r_rate}))
        else $error("divider remainder out of range");

    // The divide runs exactly sixteen steps before the gain multiply.
    a_div_length: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV && r_cnt == 4'd15) |=> (r_state == S_GAIN))
        else $error("divide did not finish after sixteen steps");

    // A fetch request only goes out while playback is active.
    a_fetch_active: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_fetch_valid) |-> o_active)
        else $error("fetch requested while stopped");

    // Loading a result always finds the output register free or being drained.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && r_out_valid && i_stall) |=> (r_state == S_DONE))
        else $error("result loaded over a stalled beat");

endmodule

`default_nettype wire

// ===== tb/lrm_checker.sv =====
`timescale 1ns / 1ps
// Scoreboard for the linear resample mixer. It predicts one result beat per accepted input
// beat from its own copy of the track state and registers. Depends on lrm_pkg.
module lrm_checker (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_in_valid,
    input  wire logic                              i_in_stall,
    input  wire logic [1:0]                        i_kind,
    input  wire logic [lrm_pkg::SAMP_W-1:0]        i_left,
    input  wire logic [lrm_pkg::SAMP_W-1:0]        i_right,
    input  wire logic                              i_out_valid,
    input  wire logic                              i_out_stall,
    input  wire logic [lrm_pkg::SAMP_W-1:0]        i_out_left,
    input  wire logic [lrm_pkg::SAMP_W-1:0]        i_out_right,
    input  wire logic                              i_fetch_valid,
    input  wire logic [lrm_pkg::IDX_W-1:0]         i_fetch_index,
    input  wire logic                              i_active,
    input  wire logic                              i_misuse,
    input  wire logic                              i_cfg_we,
    input  wire logic [lrm_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  wire logic [lrm_pkg::CFG_W-1:0]         i_cfg_data,
    output int                                     o_fail_count,
    output int                                     o_pending,
    output logic                                   o_playing,
    output logic [2:0]                             o_owed,
    output int                                     o_beats,
    output int                                     o_ticks,
    output int                                     o_wraps,
    output int                                     o_misuse
);
    import lrm_pkg::*;

    typedef struct packed {
        logic signed [SAMP_W-1:0] mix_l;
        logic signed [SAMP_W-1:0] mix_r;
        logic                     fetch_v;
        logic [IDX_W-1:0]         fetch_at;
        logic                     busy;
        logic                     misuse;
    } t_mix_beat;

    localparam int REPORT_CAP = 100;

    // Register copies.
    logic [RATE_W-1:0] rate_q;
    logic [GAIN_W-1:0] gain_q;
    logic [IDX_W-1:0]  track_len;
    logic [IDX_W-1:0]  loop_at;
    logic              loop_on;

    // Track state.
    logic signed [SAMP_W-1:0] cur_l, cur_r, nxt_l, nxt_r;
    logic [RATE_W-1:0]        phase;
    logic [IDX_W-1:0]         fetch_at;
    logic                     playing;
    logic [2:0]               owed;

    t_mix_beat mix_q[$];
    t_mix_beat got, want;

    assign o_playing = playing;
    assign o_owed    = owed;

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
        o_beats      = 0;
        o_ticks      = 0;
        o_wraps      = 0;
        o_misuse     = 0;
    end

    function automatic void stop_track();
        cur_l    = '0;
        cur_r    = '0;
        nxt_l    = '0;
        nxt_r    = '0;
        phase    = '0;
        fetch_at = '0;
        playing  = 1'b0;
        owed     = '0;
    endfunction

    // At the end of the track the fetch wraps to the loop point, or playback ends.
    function automatic void ready_fetch();
        if (!playing || owed == 0)
            return;
        if (fetch_at >= track_len) begin
            if (loop_on && loop_at < track_len) begin
                fetch_at = loop_at;
                o_wraps++;
            end else begin
                playing = 1'b0;
                owed    = '0;
            end
        end
    endfunction

    function automatic logic signed [SAMP_W-1:0] clip16(input longint v);
        if (v > 32767)
            return SAMP_MAX;
        if (v < -32768)
            return SAMP_MIN;
        return v[SAMP_W-1:0];
    endfunction

    // Interpolate between the held frames, apply the gain and add into the mix.
    // Both divisions truncate toward zero, as signed longint division does.
    function automatic logic signed [SAMP_W-1:0] blend(input logic signed [SAMP_W-1:0] a,
                                                        input logic signed [SAMP_W-1:0] b,
                                                        input logic signed [SAMP_W-1:0] m,
                                                        input int unsigned rt,
                                                        input int unsigned ph);
        longint interp;
        longint scaled;
        interp = (longint'(a) * longint'(rt - ph) + longint'(b) * longint'(ph)) / longint'(rt);
        scaled = (interp * longint'(gain_q)) / 256;
        return clip16(longint'(m) + scaled);
    endfunction

    function automatic t_mix_beat mix_beat(input t_kind k,
                                           input logic signed [SAMP_W-1:0] l,
                                           input logic signed [SAMP_W-1:0] r);
        t_mix_beat   res;
        int unsigned rt;
        int unsigned ph;
        int unsigned n;
        res = '0;
        case (k)
            KIND_START: begin
                stop_track();
                playing = 1'b1;
                owed    = 3'd2;
                ready_fetch();
            end
            KIND_FRAME: begin
                if (!playing || owed == 0) begin
                    res.misuse = 1'b1;
                end else begin
                    cur_l    = nxt_l;
                    cur_r    = nxt_r;
                    nxt_l    = l;
                    nxt_r    = r;
                    fetch_at = fetch_at + 1;
                    owed     = owed - 1;
                    ready_fetch();
                end
            end
            KIND_TICK: begin
                res.mix_l = l;
                res.mix_r = r;
                if (playing && owed != 0) begin
                    res.misuse = 1'b1;
                end else if (playing) begin
                    rt = (rate_q < MIN_RATE) ? MIN_RATE : rate_q;
                    ph = (phase >= rt) ? rt - 1 : phase;
                    res.mix_l = blend(cur_l, nxt_l, l, rt, ph);
                    res.mix_r = blend(cur_r, nxt_r, r, rt, ph);
                    ph += INPUT_RATE;
                    n = 0;
                    while (ph >= rt) begin
                        ph -= rt;
                        n++;
                    end
                    phase = ph[RATE_W-1:0];
                    owed  = n[2:0];
                    o_ticks++;
                    ready_fetch();
                end
            end
            default: stop_track();
        endcase
        res.fetch_v  = playing && owed != 0;
        res.fetch_at = res.fetch_v ? fetch_at : '0;
        res.busy     = playing;
        return res;
    endfunction

    // Printing stops after a cap so a broken block cannot flood the log; failures still count.
    function automatic void report(input string field, input string exp_s, input string act_s);
        if (o_fail_count < REPORT_CAP)
            $error("%s: expected %s, got %s", field, exp_s, act_s);
        o_fail_count++;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rate_q    = 18'd48000;
            gain_q    = 11'd256;
            track_len = '0;
            loop_at   = '0;
            loop_on   = 1'b0;
            stop_track();
            mix_q.delete();
        end else begin
            // Results are taken before new beats, so a stray result never meets a fresh entry.
            if (i_out_valid && !i_out_stall) begin
                got.mix_l    = i_out_left;
                got.mix_r    = i_out_right;
                got.fetch_v  = i_fetch_valid;
                got.fetch_at = i_fetch_index;
                got.busy     = i_active;
                got.misuse   = i_misuse;
                if (mix_q.size() == 0) begin
                    report("result", "nothing", "an unexpected beat");
                end else begin
                    want = mix_q.pop_front();
                    if (got.mix_l !== want.mix_l)
                        report("out_left", $sformatf("%0d", want.mix_l),
                               $sformatf("%0d", got.mix_l));
                    if (got.mix_r !== want.mix_r)
                        report("out_right", $sformatf("%0d", want.mix_r),
                               $sformatf("%0d", got.mix_r));
                    if (got.fetch_v !== want.fetch_v)
                        report("fetch_valid", $sformatf("%0d", want.fetch_v),
                               $sformatf("%0d", got.fetch_v));
                    if (got.fetch_at !== want.fetch_at)
                        report("fetch_index", $sformatf("%0d", want.fetch_at),
                               $sformatf("%0d", got.fetch_at));
                    if (got.busy !== want.busy)
                        report("active", $sformatf("%0d", want.busy),
                               $sformatf("%0d", got.busy));
                    if (got.misuse !== want.misuse)
                        report("misuse", $sformatf("%0d", want.misuse),
                               $sformatf("%0d", got.misuse));
                end
            end
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_OUTPUT_RATE:  rate_q    = i_cfg_data[RATE_W-1:0];
                    CFG_GAIN:         gain_q    = i_cfg_data[GAIN_W-1:0];
                    CFG_TRACK_FRAMES: track_len = i_cfg_data[IDX_W-1:0];
                    CFG_LOOP_START:   loop_at   = i_cfg_data[IDX_W-1:0];
                    CFG_LOOP_ENABLE:  loop_on   = i_cfg_data[0];
                    default: ;
                endcase
            end
            if (i_in_valid && !i_in_stall) begin
                want = mix_beat(t_kind'(i_kind), i_left, i_right);
                if (want.misuse)
                    o_misuse++;
                mix_q.push_back(want);
                o_beats++;
            end
        end
        o_pending = mix_q.size();
    end

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// Top of the linear resample mixer testbench: clock, reset, stimulus and verdict.
// Depends on lrm_pkg, linear_resample_mixer and lrm_checker.
module tb;
    import lrm_pkg::*;

    localparam int    PHASES      = 15;
    localparam int    PHASE_BEATS = 82;
    localparam int    HOLD_CYCLES = 400;
    localparam int    TAIL_CYCLES = 80;
    localparam real   TIMEOUT_NS  = 10_000_000.0;

    logic                  i_clk      = 1'b0;
    logic                  i_rst_n    = 1'b0;
    logic                  i_valid    = 1'b0;
    logic                  o_stall;
    logic [1:0]            i_kind     = '0;
    logic [SAMP_W-1:0]     i_left     = '0;
    logic [SAMP_W-1:0]     i_right    = '0;
    logic                  o_valid;
    logic                  i_stall    = 1'b0;
    logic [SAMP_W-1:0]     o_out_left;
    logic [SAMP_W-1:0]     o_out_right;
    logic                  o_fetch_valid;
    logic [IDX_W-1:0]      o_fetch_index;
    logic                  o_active;
    logic                  o_misuse;
    logic                  i_cfg_we   = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx  = '0;
    logic [CFG_W-1:0]      i_cfg_data = '0;

    int         fail_count;
    int         pending;
    logic       playing;
    logic [2:0] owed;
    int         n_beats, n_ticks, n_wraps, n_misuse;

    int idle_pct   = 15;
    bit hold_req   = 1'b0;
    int n_settings = 0;

    always #5 i_clk = ~i_clk;

    linear_resample_mixer DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_kind        (i_kind),
        .i_left        (i_left),
        .i_right       (i_right),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_out_left    (o_out_left),
        .o_out_right   (o_out_right),
        .o_fetch_valid (o_fetch_valid),
        .o_fetch_index (o_fetch_index),
        .o_active      (o_active),
        .o_misuse      (o_misuse),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data)
    );

    lrm_checker u_check (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_valid),
        .i_in_stall    (o_stall),
        .i_kind        (i_kind),
        .i_left        (i_left),
        .i_right       (i_right),
        .i_out_valid   (o_valid),
        .i_out_stall   (i_stall),
        .i_out_left    (o_out_left),
        .i_out_right   (o_out_right),
        .i_fetch_valid (o_fetch_valid),
        .i_fetch_index (o_fetch_index),
        .i_active      (o_active),
        .i_misuse      (o_misuse),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .o_fail_count  (fail_count),
        .o_pending     (pending),
        .o_playing     (playing),
        .o_owed        (owed),
        .o_beats       (n_beats),
        .o_ticks       (n_ticks),
        .o_wraps       (n_wraps),
        .o_misuse      (n_misuse)
    );

    // Receiver: random stall bursts, or one long hold when the stimulus asks for it.
    always begin
        @(negedge i_clk);
        if (hold_req) begin
            i_stall = 1'b1;
            repeat (HOLD_CYCLES) @(negedge i_clk);
            i_stall  = 1'b0;
            hold_req = 1'b0;
        end else if ($urandom_range(0, 99) < idle_pct) begin
            i_stall = 1'b1;
            repeat ($urandom_range(1, 13)) @(negedge i_clk);
            i_stall = 1'b0;
        end
    end

    initial begin
        #(TIMEOUT_NS);
        $display("== FAIL ==");
        $finish;
    end

    // Move to the next falling edge, sometimes after a gap with valid low.
    task automatic wait_slot();
        @(negedge i_clk);
        if ($urandom_range(0, 99) < idle_pct) begin
            i_valid = 1'b0;
            repeat ($urandom_range(1, 13)) @(negedge i_clk);
        end
    endtask

    task automatic offer(input t_kind k, input logic [SAMP_W-1:0] l, input logic [SAMP_W-1:0] r);
        i_valid = 1'b1;
        i_kind  = k;
        i_left  = l;
        i_right = r;
        do @(posedge i_clk); while (o_stall);
    endtask

    task automatic send(input t_kind k, input logic [SAMP_W-1:0] l, input logic [SAMP_W-1:0] r);
        wait_slot();
        offer(k, l, r);
    endtask

    // Let every expected result arrive, leaving the block idle.
    task automatic drain();
        @(negedge i_clk);
        i_valid = 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        @(negedge i_clk);
        i_cfg_we   = 1'b1;
        i_cfg_idx  = idx;
        i_cfg_data = data;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    function automatic logic [SAMP_W-1:0] pick_sample();
        case ($urandom_range(0, 7))
            0:       return SAMP_MAX;
            1:       return SAMP_MIN;
            2:       return 16'($urandom_range(0, 63)) - 16'd32;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [CFG_W-1:0] pick_rate();
        case ($urandom_range(0, 9))
            0:       return 32'd0;
            1:       return MIN_RATE - 1;
            2:       return MIN_RATE;
            3:       return 32'd22050;
            4:       return INPUT_RATE;
            5:       return 32'd48000;
            6:       return 32'd192000;
            7:       return 32'h3FFFF;
            8:       return {14'($urandom), 18'($urandom_range(11025, 192000))};
            default: return $urandom_range(11025, 192000);
        endcase
    endfunction

    function automatic logic [CFG_W-1:0] pick_gain();
        case ($urandom_range(0, 6))
            0:       return 32'd0;
            1:       return 32'd1;
            2:       return 32'd256;
            3:       return 32'd1024;
            4:       return 32'd2047;
            default: return $urandom_range(0, 1024);
        endcase
    endfunction

    task automatic new_setting();
        logic [IDX_W-1:0] len;
        logic [IDX_W-1:0] start_at;
        drain();
        case ($urandom_range(0, 5))
            0:       len = $urandom_range(0, 2);
            1:       len = 32'hFFFF_FFFF;
            default: len = $urandom_range(3, 40);
        endcase
        case ($urandom_range(0, 4))
            0:       start_at = '0;
            1:       start_at = $urandom_range(0, len);
            2:       start_at = 32'hFFFF_FFFF;
            3:       start_at = $urandom;
            default: start_at = (len != 0) ? len - 1 : '0;
        endcase
        write_reg(CFG_OUTPUT_RATE, pick_rate());
        write_reg(CFG_GAIN, pick_gain());
        write_reg(CFG_TRACK_FRAMES, len);
        write_reg(CFG_LOOP_START, start_at);
        write_reg(CFG_LOOP_ENABLE,
                  {31'($urandom_range(0, 7)), 1'($urandom_range(0, 3) != 0)});
        // Unused indexes must leave every register alone.
        if ($urandom_range(0, 3) == 0)
            write_reg(3'($urandom_range(5, 7)), $urandom);
        n_settings++;
    endtask

    // Deliver frames as long as the block asks for them.
    task automatic serve_frames();
        bit more;
        more = 1'b1;
        while (more) begin
            wait_slot();
            if (playing && owed != 0) begin
                offer(KIND_FRAME, pick_sample(), pick_sample());
            end else begin
                i_valid = 1'b0;
                more    = 1'b0;
            end
        end
    endtask

    // Mostly what the protocol wants next, with some out-of-order beats mixed in.
    task automatic random_beat();
        t_kind       k;
        int unsigned roll;
        wait_slot();
        roll = $urandom_range(0, 99);
        if (!playing)
            k = (roll < 75) ? KIND_START : t_kind'($urandom_range(0, 3));
        else if (owed != 0)
            k = (roll < 92) ? KIND_FRAME : t_kind'($urandom_range(0, 3));
        else
            k = (roll < 92) ? KIND_TICK : t_kind'($urandom_range(0, 3));
        offer(k, pick_sample(), pick_sample());
    endtask

    initial begin
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Stopped: a tick passes the mix through, a frame is refused, an empty track ends at once.
        send(KIND_TICK, SAMP_MAX, SAMP_MIN);
        send(KIND_FRAME, 16'sd1234, -16'sd1234);
        send(KIND_STOP, SAMP_MIN, SAMP_MAX);
        send(KIND_START, SAMP_MIN, SAMP_MAX);
        drain();

        // A one-frame track runs out before the second frame arrives.
        write_reg(CFG_TRACK_FRAMES, 32'd1);
        send(KIND_START, '0, '0);
        send(KIND_FRAME, SAMP_MAX, SAMP_MIN);
        drain();

        // Short looping track at the top rate and the largest gain.
        write_reg(CFG_TRACK_FRAMES, 32'd6);
        write_reg(CFG_LOOP_START, 32'd2);
        write_reg(CFG_LOOP_ENABLE, 32'd1);
        write_reg(CFG_GAIN, 32'd2047);
        write_reg(CFG_OUTPUT_RATE, 32'd192000);
        n_settings++;
        send(KIND_START, '0, '0);
        send(KIND_TICK, 16'sd100, -16'sd100);
        serve_frames();
        send(KIND_FRAME, SAMP_MAX, SAMP_MAX);
        send(KIND_TICK, SAMP_MAX, SAMP_MIN);
        send(KIND_TICK, SAMP_MIN, SAMP_MAX);
        send(KIND_TICK, '0, '0);
        drain();

        // Dropping the rate below the floor clamps the accumulated phase on the next tick.
        write_reg(CFG_OUTPUT_RATE, 32'd0);
        n_settings++;
        send(KIND_TICK, '0, '0);
        serve_frames();
        send(KIND_TICK, 16'sd1, -16'sd1);
        serve_frames();
        send(KIND_STOP, '0, '0);

        for (int p = 0; p < PHASES; p++) begin
            case ($urandom_range(0, 3))
                0:       idle_pct = 0;
                1:       idle_pct = 5;
                2:       idle_pct = 15;
                default: idle_pct = 30;
            endcase
            if (p >= PHASES - 2)
                idle_pct = 0;
            new_setting();
            // Long receiver hold while beats keep coming, so the block backs up.
            if (p == 1)
                hold_req = 1'b1;
            for (int b = 0; b < PHASE_BEATS; b++) begin
                if (b == PHASE_BEATS / 2 && $urandom_range(0, 1) == 1) begin
                    drain();
                    write_reg(CFG_OUTPUT_RATE, pick_rate());
                    if ($urandom_range(0, 1) == 1)
                        write_reg(CFG_GAIN, pick_gain());
                    n_settings++;
                end
                random_beat();
            end
        end

        drain();
        repeat (TAIL_CYCLES) @(negedge i_clk);

        $display("Covered %0d beats over %0d register settings: %0d ticks mixed, %0d loop wraps,",
                 n_beats, n_settings, n_ticks, n_wraps);
        $display("and %0d out-of-order beats flagged.", n_misuse);
        if (fail_count == 0 && pending == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/core/lrm_pkg.sv
rtl/core/lrm_csub.sv
rtl/core/lrm_mul.sv
rtl/core/linear_resample_mixer.sv
tb/lrm_checker.sv
tb/tb.sv
